// File: sv/lee_pkg.sv
// Package for the line edit echo engine: shared constants, codes, and the
// types that pass between the controller, datapath and config block.
// No dependencies.
package lee_pkg;

	localparam int LINE_DEPTH_DEF = 32;

	localparam int KEY_W     = 8;
	localparam int CAP_W     = 6;
	localparam int KIND_W    = 3;
	localparam int CHAR_W    = 8;
	localparam int STORE_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEFT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_RIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HOME   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_END    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_DELETE = 3'd5;

	localparam logic [CAP_W-1:0] RST_CAPACITY   = 6'd32;
	localparam logic [KEY_W-1:0] RST_KEY_LEFT   = 8'd128;
	localparam logic [KEY_W-1:0] RST_KEY_RIGHT  = 8'd129;
	localparam logic [KEY_W-1:0] RST_KEY_HOME   = 8'd130;
	localparam logic [KEY_W-1:0] RST_KEY_END    = 8'd131;
	localparam logic [KEY_W-1:0] RST_KEY_DELETE = 8'd132;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ECHO  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LEFT  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RIGHT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DRAW  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_BYTE  = 3'd4;
	localparam logic [KIND_W-1:0] KIND_DONE  = 3'd5;

	localparam logic [KEY_W-1:0] CH_LF       = 8'd10;
	localparam logic [KEY_W-1:0] CH_CR       = 8'd13;
	localparam logic [KEY_W-1:0] CH_BS       = 8'd8;
	localparam logic [KEY_W-1:0] CH_SPACE    = 8'd32;
	localparam logic [KEY_W-1:0] CH_PRINT_LO = 8'd32;
	localparam logic [KEY_W-1:0] CH_PRINT_HI = 8'd126;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
		logic [KEY_W-1:0] left_code;
		logic [KEY_W-1:0] right_code;
		logic [KEY_W-1:0] home_code;
		logic [KEY_W-1:0] end_code;
		logic [KEY_W-1:0] del_code;
	} cfg_t;

	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_ENTER,
		ACT_BACKSPACE,
		ACT_DELETE,
		ACT_LEFT,
		ACT_RIGHT,
		ACT_HOME,
		ACT_END,
		ACT_INSERT
	} act_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RIGHTS,
		ST_NEWLINE,
		ST_BYTE_RD,
		ST_BYTE_EM,
		ST_DONE,
		ST_LEFTS,
		ST_LEFT1,
		ST_RIGHT1,
		ST_RM_RD,
		ST_RM_WR,
		ST_IN_RD,
		ST_IN_WR,
		ST_ECHO_KEY,
		ST_TAIL_RD,
		ST_TAIL_EM,
		ST_SPACE,
		ST_LEFTN,
		ST_DRAW
	} state_t;

	typedef enum logic [1:0] {POS_HOLD, POS_INC, POS_DEC, POS_CLEAR} pos_op_t;
	typedef enum logic [2:0] {
		IDX_HOLD, IDX_CUR, IDX_CUR_M1, IDX_LEN, IDX_ZERO, IDX_INC, IDX_DEC
	} idx_op_t;
	typedef enum logic [1:0] {RD_IDX, RD_IDX_P1, RD_IDX_M1} rd_sel_t;
	typedef enum logic {WR_MOVE, WR_KEY} wr_sel_t;
	typedef enum logic [2:0] {CHR_ZERO, CHR_STORE, CHR_KEY, CHR_LF, CHR_SPACE} chr_sel_t;

	typedef struct packed {
		logic              key_load;
		pos_op_t           cur_op;
		pos_op_t           len_op;
		idx_op_t           idx_op;
		logic              cnt_load;
		logic              cnt_dec;
		logic              rd_en;
		rd_sel_t           rd_sel;
		logic              wr_en;
		wr_sel_t           wr_sel;
		logic              emit;
		logic [KIND_W-1:0] kind;
		chr_sel_t          chr_sel;
		logic              last;
	} cmd_t;

	typedef struct packed {
		act_t act;
		logic cur_lt_len;
		logic cur_gt_zero;
		logic idx_lt_len;
		logic idx_p1_lt_len;
		logic idx_gt_cur;
		logic cnt_is_one;
		logic out_free;
	} status_t;

endpackage

// File: sv/lee_cfg.sv
// Configuration registers of the line edit echo engine.
// Depends on lee_pkg.
module lee_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [lee_pkg::CFG_IDX_W-1:0] index,
	input  logic [lee_pkg::CFG_W-1:0]     wdata,
	output lee_pkg::cfg_t                 cfg
);

	lee_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.capacity   <= lee_pkg::RST_CAPACITY;
			cfg_q.left_code  <= lee_pkg::RST_KEY_LEFT;
			cfg_q.right_code <= lee_pkg::RST_KEY_RIGHT;
			cfg_q.home_code  <= lee_pkg::RST_KEY_HOME;
			cfg_q.end_code   <= lee_pkg::RST_KEY_END;
			cfg_q.del_code   <= lee_pkg::RST_KEY_DELETE;
		end else if (we) begin
			case (index)
				lee_pkg::CFG_CAPACITY:   cfg_q.capacity   <= wdata[lee_pkg::CAP_W-1:0];
				lee_pkg::CFG_KEY_LEFT:   cfg_q.left_code  <= wdata;
				lee_pkg::CFG_KEY_RIGHT:  cfg_q.right_code <= wdata;
				lee_pkg::CFG_KEY_HOME:   cfg_q.home_code  <= wdata;
				lee_pkg::CFG_KEY_END:    cfg_q.end_code   <= wdata;
				lee_pkg::CFG_KEY_DELETE: cfg_q.del_code   <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/lee_ctrl.sv
// Sequencing controller of the line edit echo engine: one state machine
// driving the datapath by command struct. Depends on lee_pkg.
module lee_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  lee_pkg::status_t st,
	output lee_pkg::cmd_t    cmd
);

	lee_pkg::state_t state_q, state_d;
	lee_pkg::act_t   act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lee_pkg::ST_IDLE;
			act_q   <= lee_pkg::ACT_NONE;
		end else begin
			state_q <= state_d;
			if (state_q == lee_pkg::ST_DECODE)
				act_q <= st.act;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lee_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_d = lee_pkg::ST_DECODE;
			end
			lee_pkg::ST_DECODE: begin
				case (st.act)
					lee_pkg::ACT_ENTER:     state_d = lee_pkg::ST_RIGHTS;
					lee_pkg::ACT_BACKSPACE: state_d = lee_pkg::ST_RM_RD;
					lee_pkg::ACT_DELETE:    state_d = lee_pkg::ST_RM_RD;
					lee_pkg::ACT_LEFT:      state_d = lee_pkg::ST_LEFT1;
					lee_pkg::ACT_RIGHT:     state_d = lee_pkg::ST_RIGHT1;
					lee_pkg::ACT_HOME:      state_d = lee_pkg::ST_LEFTS;
					lee_pkg::ACT_END:       state_d = lee_pkg::ST_RIGHTS;
					lee_pkg::ACT_INSERT:    state_d = lee_pkg::ST_IN_RD;
					default:                state_d = lee_pkg::ST_DRAW;
				endcase
			end
			lee_pkg::ST_RIGHTS: begin
				if (!st.cur_lt_len)
					state_d = (act_q == lee_pkg::ACT_ENTER) ? lee_pkg::ST_NEWLINE
						: lee_pkg::ST_DRAW;
			end
			lee_pkg::ST_NEWLINE: begin
				if (st.out_free)
					state_d = lee_pkg::ST_BYTE_RD;
			end
			lee_pkg::ST_BYTE_RD: begin
				state_d = st.idx_lt_len ? lee_pkg::ST_BYTE_EM : lee_pkg::ST_DONE;
			end
			lee_pkg::ST_BYTE_EM: begin
				if (st.out_free)
					state_d = lee_pkg::ST_BYTE_RD;
			end
			lee_pkg::ST_DONE: begin
				if (st.out_free)
					state_d = lee_pkg::ST_IDLE;
			end
			lee_pkg::ST_LEFTS: begin
				if (!st.cur_gt_zero)
					state_d = lee_pkg::ST_DRAW;
			end
			lee_pkg::ST_LEFT1: begin
				if (st.out_free)
					state_d = (act_q == lee_pkg::ACT_BACKSPACE) ? lee_pkg::ST_TAIL_RD
						: lee_pkg::ST_DRAW;
			end
			lee_pkg::ST_RIGHT1: begin
				if (st.out_free)
					state_d = lee_pkg::ST_DRAW;
			end
			lee_pkg::ST_RM_RD: begin
				if (st.idx_p1_lt_len)
					state_d = lee_pkg::ST_RM_WR;
				else
					state_d = (act_q == lee_pkg::ACT_BACKSPACE) ? lee_pkg::ST_LEFT1
						: lee_pkg::ST_TAIL_RD;
			end
			lee_pkg::ST_RM_WR: state_d = lee_pkg::ST_RM_RD;
			lee_pkg::ST_IN_RD: begin
				state_d = st.idx_gt_cur ? lee_pkg::ST_IN_WR : lee_pkg::ST_ECHO_KEY;
			end
			lee_pkg::ST_IN_WR: state_d = lee_pkg::ST_IN_RD;
			lee_pkg::ST_ECHO_KEY: begin
				if (st.out_free)
					state_d = lee_pkg::ST_TAIL_RD;
			end
			lee_pkg::ST_TAIL_RD: begin
				state_d = st.idx_lt_len ? lee_pkg::ST_TAIL_EM : lee_pkg::ST_SPACE;
			end
			lee_pkg::ST_TAIL_EM: begin
				if (st.out_free)
					state_d = lee_pkg::ST_TAIL_RD;
			end
			lee_pkg::ST_SPACE: begin
				if (st.out_free)
					state_d = lee_pkg::ST_LEFTN;
			end
			lee_pkg::ST_LEFTN: begin
				if (st.out_free && st.cnt_is_one)
					state_d = lee_pkg::ST_DRAW;
			end
			lee_pkg::ST_DRAW: begin
				if (st.out_free)
					state_d = lee_pkg::ST_IDLE;
			end
			default: state_d = lee_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			lee_pkg::ST_IDLE: begin
				s_tready     = 1'b1;
				cmd.key_load = s_tvalid;
			end
			lee_pkg::ST_DECODE: begin
				case (st.act)
					lee_pkg::ACT_BACKSPACE: begin
						cmd.cur_op = lee_pkg::POS_DEC;
						cmd.idx_op = lee_pkg::IDX_CUR_M1;
					end
					lee_pkg::ACT_DELETE: cmd.idx_op = lee_pkg::IDX_CUR;
					lee_pkg::ACT_LEFT:   cmd.cur_op = lee_pkg::POS_DEC;
					lee_pkg::ACT_RIGHT:  cmd.cur_op = lee_pkg::POS_INC;
					lee_pkg::ACT_INSERT: cmd.idx_op = lee_pkg::IDX_LEN;
					default: ;
				endcase
			end
			lee_pkg::ST_RIGHTS: begin
				if (st.cur_lt_len && st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = lee_pkg::KIND_RIGHT;
					cmd.cur_op = lee_pkg::POS_INC;
				end
			end
			lee_pkg::ST_NEWLINE: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = lee_pkg::KIND_ECHO;
					cmd.chr_sel = lee_pkg::CHR_LF;
					cmd.idx_op  = lee_pkg::IDX_ZERO;
				end
			end
			lee_pkg::ST_BYTE_RD, lee_pkg::ST_TAIL_RD: begin
				cmd.rd_en  = st.idx_lt_len;
				cmd.rd_sel = lee_pkg::RD_IDX;
			end
			lee_pkg::ST_BYTE_EM: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = lee_pkg::KIND_BYTE;
					cmd.chr_sel = lee_pkg::CHR_STORE;
					cmd.idx_op  = lee_pkg::IDX_INC;
				end
			end
			lee_pkg::ST_DONE: begin
				if (st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = lee_pkg::KIND_DONE;
					cmd.last   = 1'b1;
					cmd.cur_op = lee_pkg::POS_CLEAR;
					cmd.len_op = lee_pkg::POS_CLEAR;
				end
			end
			lee_pkg::ST_LEFTS: begin
				if (st.cur_gt_zero && st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = lee_pkg::KIND_LEFT;
					cmd.cur_op = lee_pkg::POS_DEC;
				end
			end
			lee_pkg::ST_LEFT1: begin
				if (st.out_free) begin
					cmd.emit   = 1'b1;
					cmd.kind   = lee_pkg::KIND_LEFT;
					cmd.idx_op = lee_pkg::IDX_CUR;
				end
			end
			lee_pkg::ST_RIGHT1: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = lee_pkg::KIND_RIGHT;
				end
			end
			lee_pkg::ST_RM_RD: begin
				if (st.idx_p1_lt_len) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = lee_pkg::RD_IDX_P1;
				end else begin
					cmd.len_op = lee_pkg::POS_DEC;
					cmd.idx_op = lee_pkg::IDX_CUR;
				end
			end
			lee_pkg::ST_RM_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lee_pkg::WR_MOVE;
				cmd.idx_op = lee_pkg::IDX_INC;
			end
			lee_pkg::ST_IN_RD: begin
				if (st.idx_gt_cur) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = lee_pkg::RD_IDX_M1;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_sel = lee_pkg::WR_KEY;
					cmd.len_op = lee_pkg::POS_INC;
					cmd.cur_op = lee_pkg::POS_INC;
				end
			end
			lee_pkg::ST_IN_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = lee_pkg::WR_MOVE;
				cmd.idx_op = lee_pkg::IDX_DEC;
			end
			lee_pkg::ST_ECHO_KEY: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = lee_pkg::KIND_ECHO;
					cmd.chr_sel = lee_pkg::CHR_KEY;
					cmd.idx_op  = lee_pkg::IDX_CUR;
				end
			end
			lee_pkg::ST_TAIL_EM: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = lee_pkg::KIND_ECHO;
					cmd.chr_sel = lee_pkg::CHR_STORE;
					cmd.idx_op  = lee_pkg::IDX_INC;
				end
			end
			lee_pkg::ST_SPACE: begin
				if (st.out_free) begin
					cmd.emit     = 1'b1;
					cmd.kind     = lee_pkg::KIND_ECHO;
					cmd.chr_sel  = lee_pkg::CHR_SPACE;
					cmd.cnt_load = 1'b1;
				end
			end
			lee_pkg::ST_LEFTN: begin
				if (st.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = lee_pkg::KIND_LEFT;
					cmd.cnt_dec = 1'b1;
				end
			end
			lee_pkg::ST_DRAW: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = lee_pkg::KIND_DRAW;
					cmd.last = 1'b1;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: sv/lee_dp.sv
// Datapath of the line edit echo engine: line store, length, cursor,
// loop index and counter, key decode and the output register.
// Depends on lee_pkg.
module lee_dp #(
	parameter int LINE_DEPTH = lee_pkg::LINE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [lee_pkg::KEY_W-1:0]   key,
	input  lee_pkg::cfg_t               cfg,
	input  lee_pkg::cmd_t               cmd,
	output lee_pkg::status_t            st,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lee_pkg::KIND_W-1:0]  out_kind,
	output logic [lee_pkg::CHAR_W-1:0]  out_char,
	output logic                        out_last
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int LW = $clog2(LINE_DEPTH + 1);

	logic [lee_pkg::STORE_W-1:0] mem [LINE_DEPTH];
	logic [lee_pkg::STORE_W-1:0] rd_q;
	logic [lee_pkg::KEY_W-1:0]   key_q;
	logic [LW-1:0]               len_q, cur_q, idx_q, cnt_q;
	logic [LW-1:0]               idx_p1, idx_m1;
	logic [AW-1:0]               rd_addr, wr_addr;
	logic [lee_pkg::STORE_W-1:0] wr_data;
	logic                        out_valid_q, out_last_q;
	logic [lee_pkg::KIND_W-1:0]  out_kind_q;
	logic [lee_pkg::CHAR_W-1:0]  out_char_q, chr;
	logic [lee_pkg::CAP_W-1:0]   cap_eff;
	logic                        room, printable;
	lee_pkg::act_t               act;

	assign idx_p1 = idx_q + LW'(1);
	assign idx_m1 = idx_q - LW'(1);

	// key decode, first match wins
	always_comb begin
		if (cfg.capacity > lee_pkg::CAP_W'(LINE_DEPTH))
			cap_eff = lee_pkg::CAP_W'(LINE_DEPTH);
		else if (cfg.capacity == '0)
			cap_eff = lee_pkg::CAP_W'(1);
		else
			cap_eff = cfg.capacity;
		room      = lee_pkg::CAP_W'(len_q) < (cap_eff - lee_pkg::CAP_W'(1));
		printable = (key_q >= lee_pkg::CH_PRINT_LO) && (key_q <= lee_pkg::CH_PRINT_HI);
		if (key_q == lee_pkg::CH_LF || key_q == lee_pkg::CH_CR)
			act = lee_pkg::ACT_ENTER;
		else if (key_q == lee_pkg::CH_BS && cur_q != '0)
			act = lee_pkg::ACT_BACKSPACE;
		else if (key_q == cfg.del_code && cur_q < len_q)
			act = lee_pkg::ACT_DELETE;
		else if (key_q == cfg.left_code && cur_q != '0)
			act = lee_pkg::ACT_LEFT;
		else if (key_q == cfg.right_code && cur_q < len_q)
			act = lee_pkg::ACT_RIGHT;
		else if (key_q == cfg.home_code && cur_q != '0)
			act = lee_pkg::ACT_HOME;
		else if (key_q == cfg.end_code && cur_q < len_q)
			act = lee_pkg::ACT_END;
		else if (printable && room)
			act = lee_pkg::ACT_INSERT;
		else
			act = lee_pkg::ACT_NONE;
	end

	assign st.act           = act;
	assign st.cur_lt_len    = cur_q < len_q;
	assign st.cur_gt_zero   = cur_q != '0;
	assign st.idx_lt_len    = idx_q < len_q;
	assign st.idx_p1_lt_len = idx_p1 < len_q;
	assign st.idx_gt_cur    = idx_q > cur_q;
	assign st.cnt_is_one    = cnt_q == LW'(1);
	assign st.out_free      = !out_valid_q || out_ready;

	// line store
	always_comb begin
		case (cmd.rd_sel)
			lee_pkg::RD_IDX_P1: rd_addr = idx_p1[AW-1:0];
			lee_pkg::RD_IDX_M1: rd_addr = idx_m1[AW-1:0];
			default:            rd_addr = idx_q[AW-1:0];
		endcase
		case (cmd.wr_sel)
			lee_pkg::WR_KEY: begin
				wr_addr = cur_q[AW-1:0];
				wr_data = key_q[lee_pkg::STORE_W-1:0];
			end
			default: begin
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.key_load)
			key_q <= key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cur_q <= '0;
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			case (cmd.len_op)
				lee_pkg::POS_INC:   len_q <= len_q + LW'(1);
				lee_pkg::POS_DEC:   len_q <= len_q - LW'(1);
				lee_pkg::POS_CLEAR: len_q <= '0;
				default: ;
			endcase
			case (cmd.cur_op)
				lee_pkg::POS_INC:   cur_q <= cur_q + LW'(1);
				lee_pkg::POS_DEC:   cur_q <= cur_q - LW'(1);
				lee_pkg::POS_CLEAR: cur_q <= '0;
				default: ;
			endcase
			case (cmd.idx_op)
				lee_pkg::IDX_CUR:    idx_q <= cur_q;
				lee_pkg::IDX_CUR_M1: idx_q <= cur_q - LW'(1);
				lee_pkg::IDX_LEN:    idx_q <= len_q;
				lee_pkg::IDX_ZERO:   idx_q <= '0;
				lee_pkg::IDX_INC:    idx_q <= idx_p1;
				lee_pkg::IDX_DEC:    idx_q <= idx_m1;
				default: ;
			endcase
			if (cmd.cnt_load)
				cnt_q <= len_q - cur_q + LW'(1);
			else if (cmd.cnt_dec)
				cnt_q <= cnt_q - LW'(1);
		end
	end

	// output register
	always_comb begin
		case (cmd.chr_sel)
			lee_pkg::CHR_STORE: chr = {{(lee_pkg::CHAR_W - lee_pkg::STORE_W){1'b0}}, rd_q};
			lee_pkg::CHR_KEY:   chr = key_q;
			lee_pkg::CHR_LF:    chr = lee_pkg::CH_LF;
			lee_pkg::CHR_SPACE: chr = lee_pkg::CH_SPACE;
			default:            chr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.kind;
			out_char_q <= chr;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

`ifndef NO_ASSERTIONS
	a_cur_within_line: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond line length");

	a_len_within_store: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(LINE_DEPTH - 1))
		else $error("line length beyond store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("result overwritten before transfer");

	a_left_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> cnt_q != '0)
		else $error("left-move counter underflow");
`endif

endmodule

// File: sv/line_edit_echo_engine_core.sv
// Top level of the line edit echo engine: key stream in, terminal command
// stream out. Depends on lee_pkg, lee_cfg, lee_ctrl, lee_dp.
//
//   channel  direction  payload
//   s_*      in         tdata[7:0] key
//   m_*      out        tdata[7:0] char_value; tuser[2:0] kind; tlast = last
//   cfg_*    in         index 0 capacity, 1..5 left/right/home/end/delete key
//
// Work per key: R results at one a cycle without stalls, S store entries
// shifted by a read and a write, T entries read before they are echoed or
// streamed, and the step out of each loop.
// Reset clears length and cursor, restores config defaults; store undefined.
// A stalled output holds the sequencer; the next key is taken once the
// final result of the previous one sits in the output register.
module line_edit_echo_engine_core #(
	parameter int LINE_DEPTH = lee_pkg::LINE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [lee_pkg::KEY_W-1:0]     s_tdata,   // [7:0] key
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lee_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] char_value
	output logic [lee_pkg::KIND_W-1:0]    m_tuser,   // [2:0] kind
	output logic                          m_tlast,
	input  logic                          cfg_we,
	input  logic [lee_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lee_pkg::CFG_W-1:0]     cfg_wdata
);

	lee_pkg::cfg_t                 cfg;
	lee_pkg::cmd_t                 cmd;
	lee_pkg::status_t              st;

	lee_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	lee_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lee_dp #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (s_tdata),
		.cfg       (cfg),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (m_tuser),
		.out_char  (m_tdata),
		.out_last  (m_tlast)
	);

endmodule
